FILE: rtl/pct_dec_pkg.sv
// package for the url percent decoder: escape phase type, result entry type,
// character constants and the character class helpers
// no dependencies
`default_nettype none

package pct_dec_pkg;

    localparam logic [7:0] PCT_CHAR     = 8'h25;
    localparam int         NIBBLE_SHIFT = 4;
    localparam int         MAX_RESULTS  = 3;
    localparam int         QUEUE_DEPTH  = 8;
    localparam int         QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // escape progress: nothing pending, '%' seen, '%' and one byte held
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HELD = 2'd2
    } t_phase;

    // one queued result byte with its markers
    typedef struct packed {
        logic       end_of_string;
        logic       end_of_step;
        logic [7:0] char_out;
    } t_entry;

    // ascii letter or digit, high bytes excluded
    function automatic logic is_alnum(input logic [7:0] b);
        logic res;
        res = ((b >= 8'h30) && (b <= 8'h39)) ||
              ((b >= 8'h41) && (b <= 8'h5A)) ||
              ((b >= 8'h61) && (b <= 8'h7A));
        return res;
    endfunction

    // hex value of a digit or a-f / A-F, zero for any other byte
    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        logic [3:0] res;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            res = b[3:0];
        end else if (((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66))) begin
            res = b[3:0] + 4'd9;
        end else begin
            res = 4'd0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/url_percent_decoder_keep_invalid_top.sv
// url percent decoder keeping invalid escapes, top level
// decode logic and the result queue; depends on pct_dec_pkg
`default_nettype none

// Usage
// Slave channel: one encoded string byte per transaction on i_s_axis_tdata,
// i_s_axis_tlast high on the final byte of a string.
// Master channel: decoded bytes on o_m_axis_tdata; o_m_axis_tuser is high on
// the last byte produced by one input transaction, o_m_axis_tlast on the
// last byte of a string. An input byte yields zero to three output bytes.
// Results of a byte are written into the result queue as it is accepted and,
// when the queue was empty, appear on the master side in the next cycle.
// Throughput: one input byte per cycle while the queue has room. The decode is
// a single combinational pass from the accepted byte and the escape state into
// an eight-entry result queue; input is taken while at least three entries are
// free, and the queue drains one byte per cycle while the receiver is ready.
// Reset (synchronous, active low) empties the queue and clears the escape
// state. When the receiver stalls, results wait in the queue and input is
// held off once fewer than three entries remain free.
module url_percent_decoder_keep_invalid_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave side
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  wire logic       i_s_axis_tlast,   // is_last
    // master side
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] char_out
    output logic            o_m_axis_tuser,   // [0] end_of_step
    output logic            o_m_axis_tlast    // end_of_string
);
    import pct_dec_pkg::*;

    // escape state
    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;

    // result queue
    t_entry             r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] res_cnt;
    t_entry     res [MAX_RESULTS];

    assign o_s_axis_tready = (r_count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign out_xfer        = o_m_axis_tvalid && i_m_axis_tready;

    // decode one byte into up to three results and the next escape state
    always_comb begin
        logic [7:0] c;
        logic       last;
        logic [7:0] h;
        logic [7:0] decoded;
        c       = i_s_axis_tdata;
        last    = i_s_axis_tlast;
        h       = r_held;
        decoded = {nibble_of(h), 4'd0} + {4'd0, nibble_of(c)};
        res_cnt = 2'd0;
        n_phase = r_phase;
        n_held  = r_held;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '0;
        end

        // pending escape with one held byte
        if (r_phase == PH_HELD) begin
            if (is_alnum(h) && is_alnum(c)) begin
                res[0].char_out = decoded;
                res_cnt         = 2'd1;
                n_phase         = PH_IDLE;
            end else begin
                res[0].char_out = PCT_CHAR;
                res_cnt         = 2'd1;
                if (h == PCT_CHAR) begin
                    n_phase = PH_PCT;
                end else begin
                    res[1].char_out = h;
                    res_cnt         = 2'd2;
                    n_phase         = PH_IDLE;
                end
            end
        end

        // ordinary handling of the current byte, unless consumed by a decode
        if (!((r_phase == PH_HELD) && is_alnum(h) && is_alnum(c))) begin
            if (n_phase == PH_PCT) begin
                if (last) begin
                    res[res_cnt].char_out        = PCT_CHAR;
                    res[res_cnt + 2'd1].char_out = c;
                    res_cnt                      = res_cnt + 2'd2;
                    n_phase                      = PH_IDLE;
                end else begin
                    n_held  = c;
                    n_phase = PH_HELD;
                end
            end else begin
                n_phase = PH_IDLE;
                if (c == PCT_CHAR) begin
                    if (last) begin
                        res[res_cnt].char_out = PCT_CHAR;
                        res_cnt               = res_cnt + 2'd1;
                    end else begin
                        n_phase = PH_PCT;
                    end
                end else begin
                    res[res_cnt].char_out = c;
                    res_cnt               = res_cnt + 2'd1;
                end
            end
        end

        // markers on the final result of this transaction
        if (res_cnt != 2'd0) begin
            res[res_cnt - 2'd1].end_of_step   = 1'b1;
            res[res_cnt - 2'd1].end_of_string = last;
        end

        // string end clears the escape state
        if (last) begin
            n_phase = PH_IDLE;
            n_held  = 8'd0;
        end
    end

    // queue occupancy
    always_comb begin
        n_count = r_count;
        if (in_xfer) begin
            n_count = n_count + QCNT_W'(res_cnt);
        end
        if (out_xfer) begin
            n_count = n_count - QCNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_held   <= 8'd0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_phase  <= n_phase;
                r_held   <= n_held;
                r_wr_ptr <= r_wr_ptr + QPTR_W'(res_cnt);
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (2'(i) < res_cnt) begin
                    r_queue[r_wr_ptr + QPTR_W'(i)] <= res[i];
                end
            end
        end
    end

    // master side outputs
    assign o_m_axis_tdata = r_queue[r_rd_ptr].char_out;
    assign o_m_axis_tuser = r_queue[r_rd_ptr].end_of_step;
    assign o_m_axis_tlast = r_queue[r_rd_ptr].end_of_string;

endmodule

`default_nettype wire

FILE: tb/sv/pct_dec_checker.sv
`timescale 1ns / 1ps
// checker for the url percent decoder: watches both stream channels, predicts
// the decoded bytes of every accepted input transaction and compares them
// depends on pct_dec_pkg for the phase type, the result entry and '%'
module pct_dec_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave side of the block
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,    // [7:0] char_in
    input  wire logic       i_s_tlast,    // is_last
    // master side of the block
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,    // [7:0] char_out
    input  wire logic       i_m_tuser,    // [0] end_of_step
    input  wire logic       i_m_tlast,    // end_of_string
    output int              o_fail_count,
    output int              o_pending,
    output int              o_result_count
);
    import pct_dec_pkg::*;

    localparam int MAX_PRINTS = 100;

    // predictor state
    t_phase     esc_phase = PH_IDLE;
    logic [7:0] esc_held  = '0;

    // bytes produced by the current transaction, then the decoded byte queue
    logic [7:0] step_bytes[$];
    t_entry     decoded_q[$];
    t_entry     want;

    // ascii letter or digit, nothing above 127
    function automatic bit char_is_alnum(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h41) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    // hex digit value; letters past f / F give zero
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        if ((b >= 8'h30) && (b <= 8'h39)) return 4'(b - 8'h30);
        if ((b >= 8'h41) && (b <= 8'h46)) return 4'(b - 8'h41 + 8'd10);
        if ((b >= 8'h61) && (b <= 8'h66)) return 4'(b - 8'h61 + 8'd10);
        return 4'd0;
    endfunction

    // one byte seen with no byte held: plain output, or open / extend an escape
    function void feed_plain(input logic [7:0] c, input bit last);
        if (esc_phase == PH_PCT) begin
            if (last) begin
                step_bytes.push_back(PCT_CHAR);
                step_bytes.push_back(c);
                esc_phase = PH_IDLE;
            end else begin
                esc_held  = c;
                esc_phase = PH_HELD;
            end
        end else begin
            esc_phase = PH_IDLE;
            if (c == PCT_CHAR) begin
                if (last) begin
                    step_bytes.push_back(PCT_CHAR);
                end else begin
                    esc_phase = PH_PCT;
                end
            end else begin
                step_bytes.push_back(c);
            end
        end
    endfunction

    // expected results of one input transaction, appended to the queue
    function void predict_decode(input logic [7:0] c, input bit last);
        t_entry     ent;
        logic [7:0] code;
        step_bytes.delete();
        if (esc_phase == PH_HELD) begin
            if (char_is_alnum(esc_held) && char_is_alnum(c)) begin
                code = (8'(hex_value(esc_held)) << NIBBLE_SHIFT) + 8'(hex_value(c));
                step_bytes.push_back(code);
                esc_phase = PH_IDLE;
            end else begin
                // broken escape: '%' goes out raw, both bytes are fed again
                step_bytes.push_back(PCT_CHAR);
                esc_phase = PH_IDLE;
                feed_plain(esc_held, 1'b0);
                feed_plain(c, last);
            end
        end else begin
            feed_plain(c, last);
        end
        foreach (step_bytes[i]) begin
            ent.char_out      = step_bytes[i];
            ent.end_of_step   = (i == step_bytes.size() - 1);
            ent.end_of_string = last && (i == step_bytes.size() - 1);
            decoded_q.push_back(ent);
        end
        if (last) begin
            esc_phase = PH_IDLE;
            esc_held  = '0;
        end
    endfunction

    // one line per mismatch for the first MAX_PRINTS, the log is kept short
    task report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            esc_phase = PH_IDLE;
            esc_held  = '0;
            decoded_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_decode(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result %02h with nothing expected", i_m_tdata));
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tdata !== want.char_out)
                        report_mismatch($sformatf("char_out %02h, expected %02h",
                                                  i_m_tdata, want.char_out));
                    if (i_m_tuser !== want.end_of_step)
                        report_mismatch($sformatf("end_of_step %b, expected %b on byte %02h",
                                                  i_m_tuser, want.end_of_step, want.char_out));
                    if (i_m_tlast !== want.end_of_string)
                        report_mismatch($sformatf("end_of_string %b, expected %b on byte %02h",
                                                  i_m_tlast, want.end_of_string, want.char_out));
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

FILE: tb/sv/url_percent_decoder_keep_invalid_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the url percent decoder: clock, reset, string stimulus on
// the slave channel, random back-pressure on the master channel and the verdict
// depends on pct_dec_pkg, url_percent_decoder_keep_invalid_top and pct_dec_checker
module url_percent_decoder_keep_invalid_top_tb;
    import pct_dec_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS  = 445;
    localparam int DRAIN_CYCLES  = 16;

    // classes of random bytes
    typedef enum int {
        K_PCT,
        K_HEX,
        K_PLAIN,
        K_HIGH,
        K_ANY
    } t_char_kind;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data  = '0;
    logic       s_last  = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;
    logic       m_user;
    logic       m_last;

    int fail_count;
    int pending;
    int result_count;
    int cycle_cnt    = 0;
    int items_sent   = 0;
    int strings_sent = 0;
    int sink_gap     = 0;
    bit no_idle      = 1'b0;

    string hex_chars   = "0123456789abcdefABCDEF";
    string plain_chars = "gGhHxXyYzZ/:@[`{ ~!.+-_";

    url_percent_decoder_keep_invalid_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    pct_dec_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_valid),
        .i_s_tready     (s_ready),
        .i_s_tdata      (s_data),
        .i_s_tlast      (s_last),
        .i_m_tvalid     (m_valid),
        .i_m_tready     (m_ready),
        .i_m_tdata      (m_data),
        .i_m_tuser      (m_user),
        .i_m_tlast      (m_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // idle cycles before the next transaction on either side
    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // receiver: random stall after every accepted result
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else if (m_ready && m_valid) begin
            sink_gap = draw_gap();
            m_ready <= (sink_gap == 0);
        end else if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            m_ready <= (sink_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_char(input t_char_kind kind);
        case (kind)
            K_PCT:   return PCT_CHAR;
            K_HEX:   return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
            K_PLAIN: return plain_chars[$urandom_range(0, plain_chars.len() - 1)];
            K_HIGH:  return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one input transaction, called and returning at a rising edge
    task automatic send_byte(input logic [7:0] c, input bit last);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items_sent++;
        if (last) strings_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // random string: mostly escapes with random content, some broken, some noise
    task automatic send_random_string();
        int len;
        int style;
        int pos;
        t_char_kind kind;
        len   = $urandom_range(1, 12);
        style = $urandom_range(0, 9);
        no_idle = ($urandom_range(0, 3) == 0);
        pos = 0;
        while (pos < len) begin
            if (style < 7 && pos + 3 <= len && $urandom_range(0, 1) == 1) begin
                send_byte(PCT_CHAR, 1'b0);
                send_byte(pick_char(K_HEX), 1'b0);
                send_byte(pick_char(K_HEX), pos + 3 == len);
                pos += 3;
            end else begin
                kind = (style == 9) ? K_ANY : t_char_kind'($urandom_range(0, 4));
                send_byte(pick_char(kind), pos + 1 == len);
                pos++;
            end
        end
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // timeout
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus and verdict
    initial begin
        bit paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: valid escapes in both letter cases, letters past f
        send_str("%41");
        send_str("%fF");
        send_str("%zZ");
        // escape cut short by the end of the string
        send_str("%0");
        send_str("%");
        send_str("%%");
        // broken escape that starts a new one
        send_str("%%41");
        // high byte inside an escape, three results from one byte
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("A", 1'b1);
        // zero byte is ordinary
        send_byte(8'h00, 1'b1);
        // second escape byte out of class
        send_byte(PCT_CHAR, 1'b0);
        send_byte("a", 1'b0);
        send_byte(8'h80, 1'b1);

        // random strings, with one full hold-off half way
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            send_random_string();
            if (!paused && items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                no_idle = 1'b0;
                wait_drained();
            end
        end
        no_idle = 1'b0;
        wait_drained();

        $display("sent %0d bytes in %0d strings, checked %0d decoded bytes",
                 items_sent, strings_sent, result_count);
        $display("covered valid, broken and truncated escapes, high and zero bytes, stalls");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
